/* sv/fixed_length_radix_bignum_alu_defines.svh */
// Assertion macros used by the bignum ALU top level.
`ifndef FIXED_LENGTH_RADIX_BIGNUM_ALU_DEFINES_SVH
`define FIXED_LENGTH_RADIX_BIGNUM_ALU_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while arst_n is low.
`define FLRB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and disabled while arst_n is low.
`define FLRB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/flrb_pkg.sv */
// Types and constants shared by the bignum ALU modules.
package flrb_pkg;

	localparam int ELEM_W = 14;
	localparam int IDX_W  = 8;
	localparam int DVS_W  = 32;

	typedef enum logic [2:0] {
		CMD_ASSIGN = 3'd0,
		CMD_LOAD   = 3'd1,
		CMD_ADD    = 3'd2,
		CMD_SUB    = 3'd3,
		CMD_DIV    = 3'd4,
		CMD_CMP    = 3'd5,
		CMD_READ   = 3'd6,
		CMD_NOP    = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ADD_OVF  = 2'd1,
		ST_SUB_UNF  = 2'd2,
		ST_DIV_ZERO = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REL_EQ = 2'd0,
		REL_GT = 2'd1,
		REL_LT = 2'd2
	} rel_t;

	typedef enum logic [2:0] {
		MODE_NONE,
		MODE_ADD,
		MODE_SUB,
		MODE_CMP,
		MODE_RDOUT
	} dp_mode_t;

	typedef enum logic [3:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_ASGCLR,
		FSM_ASGSET,
		FSM_LOAD,
		FSM_SCAN,
		FSM_DRAIN,
		FSM_RD,
		FSM_RDW,
		FSM_DRD,
		FSM_DLD,
		FSM_DRUN,
		FSM_DWR,
		FSM_DONE
	} fsm_t;

	typedef struct packed {
		logic     init;
		logic     clr_we;
		logic     asg_we;
		logic     ld_we;
		logic     rd;
		logic     rd_idx;
		logic     div_start;
		logic     div_wr;
		dp_mode_t mode;
	} dp_cmd_t;

	typedef struct packed {
		logic              carry;
		logic              div_zero;
		logic              div_done;
		rel_t              rel;
		logic [ELEM_W-1:0] rdv;
	} dp_stat_t;

	// Packed so that status sits in the lowest bits.
	typedef struct packed {
		logic [ELEM_W-1:0] read_value;
		rel_t              relation;
		status_t           status;
	} result_t;

endpackage

/* sv/flrb_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
module flrb_div #(
	parameter int DW = 47
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [DW-1:0]                dividend,
	input  logic [flrb_pkg::DVS_W-1:0]   divisor,
	output logic                         done,
	output logic [flrb_pkg::ELEM_W-1:0]  quo,
	output logic [flrb_pkg::DVS_W-1:0]   rem
);

	localparam int CW = $clog2(DW + 1);

	logic                         busy_q;
	logic                         done_q;
	logic [CW-1:0]                cnt_q;
	logic [DW-1:0]                dd_q;
	logic [flrb_pkg::DVS_W-1:0]   r_q;
	logic [flrb_pkg::ELEM_W-1:0]  q_q;
	logic [flrb_pkg::DVS_W:0]     trial;
	logic [flrb_pkg::DVS_W:0]     dvs_x;
	logic                         ge;
	logic [flrb_pkg::DVS_W-1:0]   r_n;

	always_comb begin
		trial = {r_q, dd_q[DW-1]};
		dvs_x = {1'b0, divisor};
		ge    = trial >= dvs_x;
		r_n   = ge ? flrb_pkg::DVS_W'(trial - dvs_x) : trial[flrb_pkg::DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dd_q <= dividend;
			r_q  <= '0;
			q_q  <= '0;
		end else if (busy_q) begin
			dd_q <= {dd_q[DW-2:0], 1'b0};
			r_q  <= r_n;
			// Only the low quotient bits are kept; the element wraps.
			q_q  <= {q_q[flrb_pkg::ELEM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = q_q;
	assign rem  = r_q;

endmodule

/* sv/flrb_dp.sv */
// Datapath: accumulator and operand memories, add/sub/compare unit, divide loop.
module flrb_dp #(
	parameter int ELEMENTS = 256,
	parameter int RADIX    = 10000
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  flrb_pkg::dp_cmd_t                  dcmd,
	input  logic [$clog2(ELEMENTS)-1:0]        addr,
	input  logic [flrb_pkg::IDX_W-1:0]         index,
	input  logic [flrb_pkg::ELEM_W-1:0]        element,
	input  logic [flrb_pkg::DVS_W-1:0]         divisor,
	output flrb_pkg::dp_stat_t                 stat
);

	localparam int AW  = $clog2(ELEMENTS);
	localparam int RW  = $clog2(RADIX);
	localparam int RMW = flrb_pkg::DVS_W + RW;
	localparam int DW  = RMW + 1;
	localparam int EW  = flrb_pkg::ELEM_W;
	localparam logic [31:0] RADIX32 = 32'(RADIX);
	localparam logic [RMW-1:0] RADIX_RM = RMW'(RADIX);

	logic [EW-1:0] acc_mem [ELEMENTS];
	logic [EW-1:0] op_mem  [ELEMENTS];

	logic [EW-1:0]   acc_rd_s1;
	logic [EW-1:0]   op_rd_s1;
	logic [AW-1:0]   addr_s1;
	logic            valid_s1;
	logic            carry_q;
	flrb_pkg::rel_t  rel_q;
	logic [EW-1:0]   rdv_q;
	logic [RMW-1:0]  rem_q;

	logic [AW-1:0]   idx_a;
	logic            idx_ok;
	logic [AW-1:0]   rd_addr;
	logic [31:0]     sum;
	logic            add_c;
	logic [31:0]     need;
	logic            sub_b;
	logic [31:0]     alu_r;
	logic            alu_we;
	logic            acc_we;
	logic [AW-1:0]   acc_wa;
	logic [EW-1:0]   acc_wd;
	logic [DW-1:0]   dividend;
	logic            div_done;
	logic [EW-1:0]   div_quo;
	logic [flrb_pkg::DVS_W-1:0] div_rem;
	logic [RMW-1:0]  prod;

	assign idx_a   = AW'(index);
	assign idx_ok  = {24'd0, index} < 32'(ELEMENTS);
	assign rd_addr = dcmd.rd_idx ? idx_a : addr;

	always_comb begin
		sum   = 32'(acc_rd_s1) + 32'(op_rd_s1) + 32'(carry_q);
		add_c = sum >= RADIX32;
		need  = 32'(op_rd_s1) + 32'(carry_q);
		sub_b = 32'(acc_rd_s1) < need;
		if (dcmd.mode == flrb_pkg::MODE_ADD) begin
			alu_r = add_c ? sum - RADIX32 : sum;
		end else begin
			alu_r = sub_b ? 32'(acc_rd_s1) + RADIX32 - need : 32'(acc_rd_s1) - need;
		end
		alu_we = valid_s1 && (dcmd.mode == flrb_pkg::MODE_ADD ||
			dcmd.mode == flrb_pkg::MODE_SUB);
	end

	always_comb begin
		acc_we = 1'b1;
		acc_wa = addr;
		acc_wd = '0;
		priority if (dcmd.clr_we) begin
			acc_wa = addr;
			acc_wd = '0;
		end else if (dcmd.asg_we) begin
			acc_wa = '0;
			acc_wd = element;
		end else if (alu_we) begin
			acc_wa = addr_s1;
			acc_wd = alu_r[EW-1:0];
		end else if (dcmd.div_wr) begin
			acc_wa = addr_s1;
			acc_wd = div_quo;
		end else begin
			acc_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.rd) begin
			acc_rd_s1 <= acc_mem[rd_addr];
			op_rd_s1  <= op_mem[rd_addr];
			addr_s1   <= rd_addr;
		end
		if (acc_we) begin
			acc_mem[acc_wa] <= acc_wd;
		end
		if (dcmd.ld_we && idx_ok) begin
			op_mem[idx_a] <= element;
		end
	end

	assign dividend = DW'(rem_q) + DW'(acc_rd_s1);
	assign prod     = RMW'(div_rem) * RADIX_RM;

	flrb_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dcmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			carry_q  <= 1'b0;
			rel_q    <= flrb_pkg::REL_EQ;
			rem_q    <= '0;
		end else begin
			valid_s1 <= dcmd.rd;
			if (dcmd.init) begin
				carry_q <= 1'b0;
				rel_q   <= flrb_pkg::REL_EQ;
				rem_q   <= '0;
			end else begin
				if (valid_s1 && dcmd.mode == flrb_pkg::MODE_ADD) begin
					carry_q <= add_c;
				end
				if (valid_s1 && dcmd.mode == flrb_pkg::MODE_SUB) begin
					carry_q <= sub_b;
				end
				if (valid_s1 && dcmd.mode == flrb_pkg::MODE_CMP &&
					rel_q == flrb_pkg::REL_EQ && acc_rd_s1 != op_rd_s1) begin
					rel_q <= (acc_rd_s1 > op_rd_s1) ? flrb_pkg::REL_GT : flrb_pkg::REL_LT;
				end
				if (dcmd.div_wr) begin
					rem_q <= prod;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.mode == flrb_pkg::MODE_RDOUT) begin
			rdv_q <= idx_ok ? acc_rd_s1 : '0;
		end
	end

	always_comb begin
		stat.carry    = carry_q;
		stat.div_zero = divisor == '0;
		stat.div_done = div_done;
		stat.rel      = rel_q;
		stat.rdv      = rdv_q;
	end

endmodule

/* sv/flrb_ctrl.sv */
// Controller: sequences each request over the element memories.
module flrb_ctrl #(
	parameter int ELEMENTS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  flrb_pkg::cmd_t                start_cmd,
	input  flrb_pkg::cmd_t                cmd,
	input  flrb_pkg::dp_stat_t            stat,
	input  logic                          out_free,
	output logic                          idle,
	output logic                          push,
	output flrb_pkg::result_t             res,
	output flrb_pkg::dp_cmd_t             dcmd,
	output logic [$clog2(ELEMENTS)-1:0]   addr
);

	localparam int AW = $clog2(ELEMENTS);

	flrb_pkg::fsm_t state_q, state_d;
	logic [AW-1:0]  cnt_q, cnt_d;
	logic           last_up;
	logic           last_dn;
	logic           up_scan;
	flrb_pkg::dp_mode_t scan_mode;

	assign last_up = cnt_q == AW'(ELEMENTS - 1);
	assign last_dn = cnt_q == '0;
	assign up_scan = cmd == flrb_pkg::CMD_CMP;

	always_comb begin
		unique case (cmd)
			flrb_pkg::CMD_ADD: scan_mode = flrb_pkg::MODE_ADD;
			flrb_pkg::CMD_SUB: scan_mode = flrb_pkg::MODE_SUB;
			default:           scan_mode = flrb_pkg::MODE_CMP;
		endcase
	end

	// Next state and element counter.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			flrb_pkg::FSM_CLEAR: begin
				cnt_d = cnt_q + AW'(1);
				if (last_up) begin
					state_d = flrb_pkg::FSM_IDLE;
					cnt_d   = '0;
				end
			end
			flrb_pkg::FSM_IDLE: begin
				if (start) begin
					cnt_d = '0;
					unique case (start_cmd)
						flrb_pkg::CMD_ASSIGN: state_d = flrb_pkg::FSM_ASGCLR;
						flrb_pkg::CMD_LOAD:   state_d = flrb_pkg::FSM_LOAD;
						flrb_pkg::CMD_ADD, flrb_pkg::CMD_SUB: begin
							state_d = flrb_pkg::FSM_SCAN;
							cnt_d   = AW'(ELEMENTS - 1);
						end
						flrb_pkg::CMD_CMP:    state_d = flrb_pkg::FSM_SCAN;
						flrb_pkg::CMD_DIV:    state_d = flrb_pkg::FSM_DRD;
						flrb_pkg::CMD_READ:   state_d = flrb_pkg::FSM_RD;
						default:              state_d = flrb_pkg::FSM_DONE;
					endcase
				end
			end
			flrb_pkg::FSM_ASGCLR: begin
				cnt_d = cnt_q + AW'(1);
				if (last_up) begin
					state_d = flrb_pkg::FSM_ASGSET;
				end
			end
			flrb_pkg::FSM_ASGSET: state_d = flrb_pkg::FSM_DONE;
			flrb_pkg::FSM_LOAD:   state_d = flrb_pkg::FSM_DONE;
			flrb_pkg::FSM_SCAN: begin
				cnt_d = up_scan ? cnt_q + AW'(1) : cnt_q - AW'(1);
				if (up_scan ? last_up : last_dn) begin
					state_d = flrb_pkg::FSM_DRAIN;
				end
			end
			flrb_pkg::FSM_DRAIN: state_d = flrb_pkg::FSM_DONE;
			flrb_pkg::FSM_RD:    state_d = flrb_pkg::FSM_RDW;
			flrb_pkg::FSM_RDW:   state_d = flrb_pkg::FSM_DONE;
			flrb_pkg::FSM_DRD: begin
				state_d = stat.div_zero ? flrb_pkg::FSM_DONE : flrb_pkg::FSM_DLD;
			end
			flrb_pkg::FSM_DLD: state_d = flrb_pkg::FSM_DRUN;
			flrb_pkg::FSM_DRUN: begin
				if (stat.div_done) begin
					state_d = flrb_pkg::FSM_DWR;
				end
			end
			flrb_pkg::FSM_DWR: begin
				cnt_d = cnt_q + AW'(1);
				state_d = last_up ? flrb_pkg::FSM_DONE : flrb_pkg::FSM_DRD;
			end
			flrb_pkg::FSM_DONE: begin
				if (out_free) begin
					state_d = flrb_pkg::FSM_IDLE;
				end
			end
			default: state_d = flrb_pkg::FSM_CLEAR;
		endcase
	end

	// Datapath commands and handshake outputs.
	always_comb begin
		dcmd = '0;
		dcmd.mode = flrb_pkg::MODE_NONE;
		idle = 1'b0;
		push = 1'b0;
		addr = cnt_q;
		unique case (state_q)
			flrb_pkg::FSM_CLEAR:  dcmd.clr_we = 1'b1;
			flrb_pkg::FSM_IDLE: begin
				idle      = 1'b1;
				dcmd.init = start;
			end
			flrb_pkg::FSM_ASGCLR: dcmd.clr_we = 1'b1;
			flrb_pkg::FSM_ASGSET: dcmd.asg_we = 1'b1;
			flrb_pkg::FSM_LOAD:   dcmd.ld_we  = 1'b1;
			flrb_pkg::FSM_SCAN: begin
				dcmd.rd   = 1'b1;
				dcmd.mode = scan_mode;
			end
			flrb_pkg::FSM_DRAIN:  dcmd.mode = scan_mode;
			flrb_pkg::FSM_RD: begin
				dcmd.rd     = 1'b1;
				dcmd.rd_idx = 1'b1;
			end
			flrb_pkg::FSM_RDW:    dcmd.mode = flrb_pkg::MODE_RDOUT;
			flrb_pkg::FSM_DRD:    dcmd.rd = !stat.div_zero;
			flrb_pkg::FSM_DLD:    dcmd.div_start = 1'b1;
			flrb_pkg::FSM_DRUN:   dcmd.mode = flrb_pkg::MODE_NONE;
			flrb_pkg::FSM_DWR:    dcmd.div_wr = 1'b1;
			flrb_pkg::FSM_DONE:   push = out_free;
			default:              dcmd.mode = flrb_pkg::MODE_NONE;
		endcase
	end

	always_comb begin
		res.status = flrb_pkg::ST_OK;
		unique case (cmd)
			flrb_pkg::CMD_ADD: if (stat.carry) res.status = flrb_pkg::ST_ADD_OVF;
			flrb_pkg::CMD_SUB: if (stat.carry) res.status = flrb_pkg::ST_SUB_UNF;
			flrb_pkg::CMD_DIV: if (stat.div_zero) res.status = flrb_pkg::ST_DIV_ZERO;
			default:           res.status = flrb_pkg::ST_OK;
		endcase
		res.relation   = (cmd == flrb_pkg::CMD_CMP) ? stat.rel : flrb_pkg::REL_EQ;
		res.read_value = (cmd == flrb_pkg::CMD_READ) ? stat.rdv : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flrb_pkg::FSM_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

/* sv/fixed_length_radix_bignum_alu.sv */
// Top level of the fixed-length multiprecision radix ALU.
//
// The block holds an accumulator of ELEMENTS digits in radix RADIX (element 0
// is the integer part) and an operand store loaded one element per request.
// Requests arrive on the s_axis stream and every request yields exactly one
// response on the m_axis stream carrying status, relation and read value.
// A request is taken only while the block is idle; one request is in work
// at a time, walking the element memories through their single read port.
// Assign, add, subtract and compare each walk all ELEMENTS entries; the
// bit-serial divider takes DW = 33+ceil(log2(RADIX)) steps per element
// (47 at the default radix).
// After reset the accumulator is cleared by a pass over all ELEMENTS
// entries, one per cycle, and no request is accepted during that pass.
// The response waits in an output register; the block takes the next
// request while it waits, but will not finish that request until the
// receiver has drained the register.
module fixed_length_radix_bignum_alu #(
	parameter int ELEMENTS = 256,
	parameter int RADIX    = 10000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// cmd[2:0], index[10:3], element[24:11], divisor[56:25], zero pad[63:57]
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[1:0], relation[3:2], read_value[17:4], zero pad[23:18]
	output logic [23:0] m_axis_tdata
);

	`include "fixed_length_radix_bignum_alu_defines.svh"

	localparam int AW = $clog2(ELEMENTS);

	// Fields of the incoming request.
	flrb_pkg::cmd_t                 in_cmd;
	logic                           accept;

	// Request held for the duration of its work.
	flrb_pkg::cmd_t                 req_cmd_q;
	logic [flrb_pkg::IDX_W-1:0]     req_index_q;
	logic [flrb_pkg::ELEM_W-1:0]    req_element_q;
	logic [flrb_pkg::DVS_W-1:0]     req_divisor_q;

	flrb_pkg::dp_cmd_t              dcmd;
	flrb_pkg::dp_stat_t             stat;
	logic [AW-1:0]                  addr;
	logic                           idle;
	logic                           push;
	flrb_pkg::result_t              res;

	// Response output register.
	logic                           out_valid_q;
	flrb_pkg::result_t              res_q;
	logic                           out_free;

	assign in_cmd        = flrb_pkg::cmd_t'(s_axis_tdata[2:0]);
	assign s_axis_tready = idle;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Payload registers are captured on accept and need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_index_q   <= s_axis_tdata[10:3];
			req_element_q <= s_axis_tdata[24:11];
			req_divisor_q <= s_axis_tdata[56:25];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_cmd_q <= flrb_pkg::CMD_NOP;
		end else if (accept) begin
			req_cmd_q <= in_cmd;
		end
	end

	flrb_ctrl #(.ELEMENTS(ELEMENTS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.start_cmd (in_cmd),
		.cmd       (req_cmd_q),
		.stat      (stat),
		.out_free  (out_free),
		.idle      (idle),
		.push      (push),
		.res       (res),
		.dcmd      (dcmd),
		.addr      (addr)
	);

	flrb_dp #(.ELEMENTS(ELEMENTS), .RADIX(RADIX)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.dcmd    (dcmd),
		.addr    (addr),
		.index   (req_index_q),
		.element (req_element_q),
		.divisor (req_divisor_q),
		.stat    (stat)
	);

	// The output register is loaded when the controller finishes a request and
	// emptied when the receiver takes the response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, res_q};

	`FLRB_ASSERT_NXT(a_one_request_in_work, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while another is in work")
	`FLRB_ASSERT_IMP(a_push_slot_free, push, !out_valid_q || m_axis_tready, "response overwrote an untaken response")
	`FLRB_ASSERT_IMP(a_div_zero_clean, m_axis_tvalid && res_q.status == flrb_pkg::ST_DIV_ZERO, res_q.relation == flrb_pkg::REL_EQ && res_q.read_value == 14'd0, "divide-by-zero response carries stray fields")

endmodule
